// ===== src/pngu_pkg.sv =====
`timescale 1ns / 1ps
// Package for the PNG scanline unfilter: sizes, filter and register codes,
// the control word between the position tracker and the datapath, and the Paeth predictor.
// No dependencies.
package pngu_pkg;

	localparam int MAX_ROW_BYTES   = 8192;
	localparam int MAX_PIXEL_BYTES = 8;
	localparam int ADDR_W          = $clog2(MAX_ROW_BYTES);
	localparam int COL_W           = $clog2(MAX_ROW_BYTES + 1);
	localparam int PSEL_W          = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
	localparam int PB_W            = 4;
	localparam int RB_W            = 14;
	localparam int RC_W            = 16;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 16;

	typedef enum logic [2:0] {
		FILT_NONE  = 3'd0,
		FILT_SUB   = 3'd1,
		FILT_UP    = 3'd2,
		FILT_AVG   = 3'd3,
		FILT_PAETH = 3'd4,
		FILT_BAD   = 3'd5
	} filt_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PIXEL_BYTES = 2'd0,
		REG_ROW_BYTES   = 2'd1,
		REG_ROW_COUNT   = 2'd2
	} reg_idx_t;

	// Control word that travels with each byte into the reconstruction stage.
	typedef struct packed {
		logic              is_type;
		logic              bad;
		logic              last;
		logic              prior_ok;
		logic              left_ok;
		filt_t             ftype;
		logic [ADDR_W-1:0] col;
		logic [PSEL_W-1:0] pb_sel;
	} pngu_meta_t;

	function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		logic signed [10:0] sa, sb, sc, da, db, dc;
		begin
			sa = signed'({3'b000, a});
			sb = signed'({3'b000, b});
			sc = signed'({3'b000, c});
			da = sb - sc;
			db = sa - sc;
			dc = sa + sb - (sc <<< 1);
			if (da < 0) da = -da;
			if (db < 0) db = -db;
			if (dc < 0) dc = -dc;
			if (da <= db && da <= dc) paeth = a;
			else if (db <= dc) paeth = b;
			else paeth = c;
		end
	endfunction

endpackage

// ===== src/pngu_in_if.sv =====
`timescale 1ns / 1ps
// Input channel of the unfilter: one filtered stream byte per word.
// Depends on nothing.
interface pngu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

// ===== src/pngu_out_if.sv =====
`timescale 1ns / 1ps
// Output channel of the unfilter: one reconstructed byte and its flags per word.
// Depends on nothing.
interface pngu_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       is_type_byte;
	logic       bad_type;
	logic       last_of_image;

	modport source (output valid, output out_byte, output is_type_byte, output bad_type,
		output last_of_image, input ready);
	modport sink (input valid, input out_byte, input is_type_byte, input bad_type,
		input last_of_image, output ready);
endinterface

// ===== src/pngu_cfg_if.sv =====
`timescale 1ns / 1ps
// Configuration write channel: register index and write data.
// Depends on pngu_pkg for the field widths.
interface pngu_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [pngu_pkg::CFG_IDX_W-1:0]  index;
	logic [pngu_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/png_scanline_unfilter_top.sv =====
`timescale 1ns / 1ps
// PNG scanline unfilter, top level.
// Depends on pngu_pkg, the three channel interfaces, pngu_ctrl and pngu_recon.
//
// The stream channel takes the filtered image one byte per word, the filter-type
// byte first on every scanline. The result channel gives one word per input word:
// the reconstructed byte, or the type byte unchanged with is_type_byte set,
// plus bad_type for rows whose type exceeds 4 and last_of_image on the final
// data byte of the last row. The cfg channel writes pixel_bytes (index 0),
// row_bytes (index 1) and row_count (index 2); it is always ready. The user must
// write it only while no byte is in flight; the block itself does not enforce this.
// From acceptance to result valid, the accepted byte and its line-store read sit
// in one stage, then the result register. Throughput is one byte per cycle while
// the receiver takes results; the line-store read and the Paeth predictor with one
// add set the cycle.
// Reset returns the registers to 4, 4096 and 1, clears the windows and waits for
// the type byte of a first row. The line store is not cleared; row zero never
// reads it. When the receiver stalls, the result register holds and the stage
// behind it fills, after which stream ready drops until the result is taken.
module png_scanline_unfilter_top (
	input  logic        clk,
	input  logic        arst_n,
	pngu_in_if.sink     stream,
	pngu_out_if.source  result,
	pngu_cfg_if.sink    cfg
);
	import pngu_pkg::*;

	logic              take;
	logic              free;
	pngu_meta_t        meta;
	logic [ADDR_W-1:0] rd_addr;

	assign stream.ready = free;
	assign take         = stream.valid && free;

	pngu_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.take    (take),
		.in_byte (stream.in_byte),
		.meta    (meta),
		.rd_addr (rd_addr)
	);

	pngu_recon u_recon (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.in_byte (stream.in_byte),
		.meta    (meta),
		.rd_addr (rd_addr),
		.free    (free),
		.result  (result)
	);

endmodule

// ===== src/pngu_ctrl.sv =====
`timescale 1ns / 1ps
// Configuration registers and the column/row/filter-type tracker of the unfilter.
// Depends on pngu_pkg and pngu_cfg_if.
module pngu_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	pngu_cfg_if.sink                    cfg,
	input  logic                        take,
	input  logic [7:0]                  in_byte,
	output pngu_pkg::pngu_meta_t        meta,
	output logic [pngu_pkg::ADDR_W-1:0] rd_addr
);
	import pngu_pkg::*;

	logic [PB_W-1:0]  pixel_bytes_q;
	logic [RB_W-1:0]  row_bytes_q;
	logic [RC_W-1:0]  row_count_q;
	logic [COL_W-1:0] col_q;
	logic [RC_W-1:0]  row_q;
	filt_t            type_q;

	logic [PB_W-1:0]  pb_eff;
	logic [RB_W-1:0]  rb_eff;
	logic [RC_W-1:0]  rc_eff;
	logic [COL_W-1:0] col_data;
	logic             row_end;
	logic             img_end;
	filt_t            new_type;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_bytes_q <= PB_W'(4);
			row_bytes_q   <= RB_W'(4096);
			row_count_q   <= RC_W'(1);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_PIXEL_BYTES: pixel_bytes_q <= cfg.data[PB_W-1:0];
				REG_ROW_BYTES:   row_bytes_q   <= cfg.data[RB_W-1:0];
				REG_ROW_COUNT:   row_count_q   <= cfg.data[RC_W-1:0];
				default:         ;
			endcase
		end
	end

	always_comb begin
		if (pixel_bytes_q == '0) pb_eff = PB_W'(1);
		else if (pixel_bytes_q > PB_W'(MAX_PIXEL_BYTES)) pb_eff = PB_W'(MAX_PIXEL_BYTES);
		else pb_eff = pixel_bytes_q;

		if (row_bytes_q == '0) rb_eff = RB_W'(1);
		else if (row_bytes_q > RB_W'(MAX_ROW_BYTES)) rb_eff = RB_W'(MAX_ROW_BYTES);
		else rb_eff = row_bytes_q;

		rc_eff   = (row_count_q == '0) ? RC_W'(1) : row_count_q;
		col_data = col_q - COL_W'(1);
		row_end  = col_q >= COL_W'(rb_eff);
		img_end  = ({1'b0, row_q} + 17'd1) >= {1'b0, rc_eff};
		new_type = (in_byte > 8'd4) ? FILT_BAD : filt_t'(in_byte[2:0]);
	end

	always_comb begin
		meta.is_type  = (col_q == '0);
		meta.ftype    = meta.is_type ? new_type : type_q;
		meta.bad      = (meta.ftype == FILT_BAD);
		meta.last     = !meta.is_type && row_end && img_end;
		meta.prior_ok = (row_q != '0);
		meta.left_ok  = COL_W'(col_data) >= COL_W'(pb_eff);
		meta.col      = col_data[ADDR_W-1:0];
		meta.pb_sel   = PSEL_W'(pb_eff - PB_W'(1));
	end

	assign rd_addr = col_data[ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			type_q <= FILT_NONE;
		end else if (take) begin
			if (col_q == '0) begin
				type_q <= new_type;
				col_q  <= COL_W'(1);
			end else if (row_end) begin
				col_q <= '0;
				row_q <= img_end ? '0 : row_q + RC_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

endmodule

// ===== src/pngu_recon.sv =====
`timescale 1ns / 1ps
// Reconstruction stage: line store, left and upper-left windows, predictors and
// the output register. Depends on pngu_pkg and pngu_out_if.
module pngu_recon (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        take,
	input  logic [7:0]                  in_byte,
	input  pngu_pkg::pngu_meta_t        meta,
	input  logic [pngu_pkg::ADDR_W-1:0] rd_addr,
	output logic                        free,
	pngu_out_if.source                  result
);
	import pngu_pkg::*;

	logic [7:0] line_mem [MAX_ROW_BYTES];
	logic [7:0] rd_q;
	logic [7:0] left_q [MAX_PIXEL_BYTES];
	logic [7:0] ul_q [MAX_PIXEL_BYTES];

	logic       valid_s1;
	logic [7:0] byte_s1;
	pngu_meta_t meta_s1;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_type_q;
	logic       out_bad_q;
	logic       out_last_q;

	logic       advance;
	logic [7:0] a, b, c, pred, rec;
	logic [8:0] sum_ab;

	assign advance = valid_s1 && (!out_valid_q || result.ready);
	assign free    = !valid_s1 || advance;

	// Read is issued when the byte is accepted; the data waits with the byte.
	always_ff @(posedge clk) begin
		if (take) rd_q <= line_mem[rd_addr];
		if (advance && !meta_s1.is_type) line_mem[meta_s1.col] <= rec;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= in_byte;
			meta_s1 <= meta;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (take) valid_s1 <= 1'b1;
		else if (advance) valid_s1 <= 1'b0;
	end

	always_comb begin
		a      = meta_s1.left_ok ? left_q[meta_s1.pb_sel] : 8'd0;
		b      = meta_s1.prior_ok ? rd_q : 8'd0;
		c      = (meta_s1.left_ok && meta_s1.prior_ok) ? ul_q[meta_s1.pb_sel] : 8'd0;
		sum_ab = {1'b0, a} + {1'b0, b};
		case (meta_s1.ftype)
			FILT_SUB:   pred = a;
			FILT_UP:    pred = b;
			FILT_AVG:   pred = sum_ab[8:1];
			FILT_PAETH: pred = paeth(a, b, c);
			default:    pred = 8'd0;
		endcase
		rec = byte_s1 + pred;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
				left_q[i] <= 8'd0;
				ul_q[i]   <= 8'd0;
			end
		end else if (advance) begin
			if (meta_s1.is_type) begin
				for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
					left_q[i] <= 8'd0;
					ul_q[i]   <= 8'd0;
				end
			end else begin
				for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
					left_q[i] <= left_q[i-1];
					ul_q[i]   <= ul_q[i-1];
				end
				left_q[0] <= rec;
				ul_q[0]   <= b;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q <= meta_s1.is_type ? byte_s1 : rec;
			out_type_q <= meta_s1.is_type;
			out_bad_q  <= meta_s1.bad;
			out_last_q <= meta_s1.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (advance) out_valid_q <= 1'b1;
		else if (result.ready) out_valid_q <= 1'b0;
	end

	assign result.valid         = out_valid_q;
	assign result.out_byte      = out_byte_q;
	assign result.is_type_byte  = out_type_q;
	assign result.bad_type      = out_bad_q;
	assign result.last_of_image = out_last_q;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for png_scanline_unfilter_top: a scoreboard class predicts every
// result word and plain tasks drive the stream channel with random idling and the cfg channel.
// Depends on pngu_pkg, the three channel interfaces and the unfilter RTL.

typedef struct {
	logic [7:0] data;
	logic       is_type;
	logic       bad;
	logic       last;
} recon_word_t;

class recon_scoreboard;
	logic [3:0]      pix_reg;
	logic [13:0]     row_len_reg;
	logic [15:0]     row_cnt_reg;
	logic [7:0]      line_store [pngu_pkg::MAX_ROW_BYTES];
	logic [7:0]      left_win [pngu_pkg::MAX_PIXEL_BYTES];
	logic [7:0]      upleft_win [pngu_pkg::MAX_PIXEL_BYTES];
	int unsigned     col_pos;
	int unsigned     row_pos;
	pngu_pkg::filt_t row_filter;
	recon_word_t     expected_words [$];
	int              mismatches;

	function new();
		pix_reg = 4'd4;
		row_len_reg = 14'd4096;
		row_cnt_reg = 16'd1;
		foreach (line_store[i]) line_store[i] = 8'h00;
		foreach (left_win[i]) begin
			left_win[i] = 8'h00;
			upleft_win[i] = 8'h00;
		end
		col_pos = 0;
		row_pos = 0;
		row_filter = pngu_pkg::FILT_NONE;
		mismatches = 0;
	endfunction

	function void set_reg(pngu_pkg::reg_idx_t idx, logic [15:0] v);
		case (idx)
			pngu_pkg::REG_PIXEL_BYTES: pix_reg = v[3:0];
			pngu_pkg::REG_ROW_BYTES: row_len_reg = v[13:0];
			pngu_pkg::REG_ROW_COUNT: row_cnt_reg = v;
			default: ;
		endcase
	endfunction

	function int unsigned pixel_step();
		if (pix_reg == 0) return 1;
		if (pix_reg > pngu_pkg::MAX_PIXEL_BYTES) return pngu_pkg::MAX_PIXEL_BYTES;
		return pix_reg;
	endfunction

	function int unsigned row_len();
		if (row_len_reg == 0) return 1;
		if (row_len_reg > pngu_pkg::MAX_ROW_BYTES) return pngu_pkg::MAX_ROW_BYTES;
		return row_len_reg;
	endfunction

	function logic [7:0] paeth_pick(logic [7:0] a, logic [7:0] b, logic [7:0] c);
		int dist_a, dist_b, dist_c;
		dist_a = int'(b) - int'(c);
		dist_b = int'(a) - int'(c);
		dist_c = int'(a) + int'(b) - 2 * int'(c);
		if (dist_a < 0) dist_a = -dist_a;
		if (dist_b < 0) dist_b = -dist_b;
		if (dist_c < 0) dist_c = -dist_c;
		if (dist_a <= dist_b && dist_a <= dist_c) return a;
		if (dist_b <= dist_c) return b;
		return c;
	endfunction

	// Works out the result word for one accepted stream byte and queues it.
	function void note_byte(logic [7:0] x);
		recon_word_t w;
		int unsigned step, len, rows, col;
		logic [7:0] a, b, c, pred, rec;
		logic [8:0] sum;
		step = pixel_step();
		len = row_len();
		rows = (row_cnt_reg == 0) ? 1 : row_cnt_reg;
		if (col_pos == 0) begin
			row_filter = (x > 8'd4) ? pngu_pkg::FILT_BAD : pngu_pkg::filt_t'(x[2:0]);
			foreach (left_win[i]) begin
				left_win[i] = 8'h00;
				upleft_win[i] = 8'h00;
			end
			col_pos = 1;
			w.data = x;
			w.is_type = 1'b1;
			w.bad = (row_filter == pngu_pkg::FILT_BAD);
			w.last = 1'b0;
		end else begin
			col = col_pos - 1;
			a = 8'h00;
			b = 8'h00;
			c = 8'h00;
			if (col >= step) a = left_win[step - 1];
			if (row_pos != 0 && col < pngu_pkg::MAX_ROW_BYTES) b = line_store[col];
			if (row_pos != 0 && col >= step) c = upleft_win[step - 1];
			sum = {1'b0, a} + {1'b0, b};
			case (row_filter)
				pngu_pkg::FILT_SUB: pred = a;
				pngu_pkg::FILT_UP: pred = b;
				pngu_pkg::FILT_AVG: pred = sum[8:1];
				pngu_pkg::FILT_PAETH: pred = paeth_pick(a, b, c);
				default: pred = 8'h00;
			endcase
			rec = x + pred;
			for (int i = pngu_pkg::MAX_PIXEL_BYTES - 1; i > 0; i--) begin
				left_win[i] = left_win[i - 1];
				upleft_win[i] = upleft_win[i - 1];
			end
			left_win[0] = rec;
			upleft_win[0] = b;
			if (col < pngu_pkg::MAX_ROW_BYTES) line_store[col] = rec;
			w.data = rec;
			w.is_type = 1'b0;
			w.bad = (row_filter == pngu_pkg::FILT_BAD);
			w.last = 1'b0;
			// A shortened row ends on the first byte at or past the new length.
			if (col_pos >= len) begin
				col_pos = 0;
				if (row_pos + 1 >= rows) begin
					w.last = 1'b1;
					row_pos = 0;
				end else begin
					row_pos = (row_pos + 1) & 16'hFFFF;
				end
			end else begin
				col_pos++;
			end
		end
		expected_words.push_back(w);
	endfunction

	function void check_word(logic [7:0] d, logic t, logic b, logic l);
		recon_word_t e;
		if (expected_words.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result word: byte %h type %b bad %b last %b", d, t, b, l);
			return;
		end
		e = expected_words.pop_front();
		if (e.data !== d || e.is_type !== t || e.bad !== b || e.last !== l) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch at %0t: byte %h/%h type %b/%b bad %b/%b last %b/%b (exp/act)",
					$time, e.data, d, e.is_type, t, e.bad, b, e.last, l);
		end
	endfunction
endclass

module tb;
	import pngu_pkg::*;

	logic            clk;
	logic            arst_n;
	int              src_idle_pct;
	int              sink_stall_pct;
	recon_scoreboard sb;

	pngu_in_if  stream_if ();
	pngu_out_if result_if ();
	pngu_cfg_if cfg_if ();

	png_scanline_unfilter_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_if),
		.result (result_if),
		.cfg    (cfg_if)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("FAILURE");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && result_if.valid && result_if.ready)
			sb.check_word(result_if.out_byte, result_if.is_type_byte, result_if.bad_type,
				result_if.last_of_image);
		result_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	task automatic push_byte(input logic [7:0] v);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			stream_if.valid <= 1'b0;
			@(posedge clk);
		end
		stream_if.valid <= 1'b1;
		stream_if.in_byte <= v;
		@(posedge clk);
		while (!stream_if.ready) @(posedge clk);
		sb.note_byte(v);
	endtask

	task automatic drain();
		stream_if.valid <= 1'b0;
		while (sb.expected_words.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [15:0] v);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= v;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		sb.set_reg(idx, v);
	endtask

	task automatic set_config(input logic [15:0] pb_v, input logic [15:0] rb_v,
			input logic [15:0] rc_v);
		write_reg(REG_PIXEL_BYTES, pb_v);
		write_reg(REG_ROW_BYTES, rb_v);
		write_reg(REG_ROW_COUNT, rc_v);
		cfg_if.valid <= 1'b0;
	endtask

	// Streams one image; at byte change_at the block is drained and reprogrammed.
	task automatic run_image(input int change_at, input logic [15:0] pb2,
			input logic [15:0] rb2, input logic [15:0] rc2, output int sent);
		logic [7:0] v;
		sent = 0;
		do begin
			if (sent == change_at) begin
				drain();
				set_config(pb2, rb2, rc2);
			end
			if (sb.col_pos == 0) begin
				if ($urandom_range(0, 9) == 0) v = 8'($urandom_range(5, 255));
				else v = 8'($urandom_range(0, 4));
			end else begin
				v = 8'($urandom);
			end
			push_byte(v);
			sent++;
		end while (sb.col_pos != 0 || sb.row_pos != 0);
	endtask

	initial begin
		logic [7:0] row_data [10] = '{8'hFF, 8'h01, 8'h80, 8'hFF, 8'h00, 8'hFF, 8'hFF,
			8'h7F, 8'h10, 8'hEF};
		int img, counted, sent, change_at, pix, rlen, rcnt;
		logic [15:0] rb_new;
		sb = new();
		arst_n = 1'b0;
		stream_if.valid = 1'b0;
		stream_if.in_byte = 8'h00;
		result_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = REG_PIXEL_BYTES;
		cfg_if.data = 16'h0000;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: four-byte pixels on a 4096-byte row, sub filter.
		push_byte(8'd1);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'h80);
		push_byte(8'h7F);
		push_byte(8'h01);
		// Zero registers act as one, so the open row and the image end on the next word.
		drain();
		set_config(16'd0, 16'd0, 16'd0);
		push_byte(8'hC3);
		// Unknown types on one-byte rows, pixel size clamped to eight.
		drain();
		set_config(16'd15, 16'd1, 16'd2);
		push_byte(8'd5);
		push_byte(8'h12);
		push_byte(8'd255);
		push_byte(8'h34);
		// Every filter in turn on two-byte rows.
		drain();
		set_config(16'd1, 16'd2, 16'd5);
		for (int t = 0; t <= 4; t++) begin
			push_byte(8'(t));
			push_byte(row_data[2 * t]);
			push_byte(row_data[2 * t + 1]);
		end

		img = 0;
		counted = 0;
		while (counted < 1900) begin
			drain();
			case ((img / 2) % 4)
				0: begin
					src_idle_pct = 0;
					sink_stall_pct = 0;
				end
				1: begin
					src_idle_pct = 46;
					sink_stall_pct = 0;
				end
				2: begin
					src_idle_pct = 0;
					sink_stall_pct = 46;
				end
				default: begin
					src_idle_pct = 27;
					sink_stall_pct = 27;
				end
			endcase
			if (img == 4) begin
				// Largest row count, cut short after twenty rows.
				set_config(16'd3, 16'd1, 16'd65535);
				run_image(40, 16'd3, 16'd1, 16'd1, sent);
			end else if (img == 8) begin
				// Longest row setting; the first row is cut short once well under way.
				set_config(16'd8, 16'd8192, 16'd2);
				run_image(300, 16'd8, 16'd24, 16'd2, sent);
			end else if (img == 12) begin
				set_config(16'hFFFF, 16'hFFFF, 16'd1);
				run_image(300, 16'hFFFF, 16'd40, 16'd2, sent);
			end else begin
				if ($urandom_range(0, 9) == 0)
					pix = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(9, 15);
				else
					pix = $urandom_range(1, 8);
				case ($urandom_range(0, 9))
					0: rlen = 0;
					1: rlen = $urandom_range(25, 300);
					default: rlen = $urandom_range(1, 24);
				endcase
				rcnt = ($urandom_range(0, 12) == 0) ? 0 : $urandom_range(1, 6);
				set_config({12'($urandom), 4'(pix)}, {2'($urandom), 14'(rlen)}, 16'(rcnt));
				if (rlen == 0) rlen = 1;
				if (rcnt == 0) rcnt = 1;
				change_at = -1;
				rb_new = 16'd0;
				// Rows may only shrink mid-image, so the line store is always written.
				if ($urandom_range(0, 5) == 0) begin
					change_at = $urandom_range(1, rcnt * (rlen + 1) - 1);
					rb_new = 16'($urandom_range(1, rlen));
				end
				run_image(change_at, 16'($urandom_range(0, 15)), rb_new,
					16'($urandom_range(1, 8)), sent);
			end
			counted += sent;
			img++;
		end

		drain();
		repeat (5) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
